### sv/ltc_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types of the lru tag cache
// no dependencies; compiled first

package ltc_pkg;

  // sizing
  localparam int SLOTS      = 64;
  localparam int KEY_BITS   = 48;
  localparam int FRAME_BITS = 32;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int USED_W     = $clog2(SLOTS + 1);
  localparam int CAP_W      = 7;
  localparam int AGE_W      = 8;
  localparam int CAPX_W     = (CAP_W > USED_W) ? CAP_W : USED_W;
  localparam int CNT_W      = 32;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_THRESHOLD = 1'b1;

  localparam int CAP_RESET = 64;
  localparam int AGE_RESET = 5;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_CLEAR  = 2'd3
  } ltc_kind_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_NOCACHE  = 3'd2,
    ST_ALLOC    = 3'd3,
    ST_REPLACED = 3'd4,
    ST_REJECTED = 3'd5,
    ST_DONE     = 3'd6
  } ltc_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DECIDE,
    S_RESULT
  } ltc_state_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              classify;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              cmp_en;
    logic [SLOT_W-1:0] cmp_idx;
    logic              decide;
    logic              commit;
  } ltc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              need_scan;
    logic              found;
    logic [USED_W-1:0] used_cnt;
    logic              out_free;
  } ltc_sts_t;

endpackage

### sv/ltc_in_if.sv
`timescale 1ns / 1ps
// request channel: valid/ready plus one request beat
// depends on ltc_pkg

interface ltc_in_if import ltc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  ltc_kind_t             kind;
  logic [KEY_BITS-1:0]   key;
  logic                  cacheable;
  logic [FRAME_BITS-1:0] frame_now;

  modport source (output valid, kind, key, cacheable, frame_now, input ready);
  modport sink   (input valid, kind, key, cacheable, frame_now, output ready);
endinterface

### sv/ltc_out_if.sv
`timescale 1ns / 1ps
// result channel: valid/ready plus one result beat
// depends on ltc_pkg

interface ltc_out_if import ltc_pkg::*; ();
  logic              valid;
  logic              ready;
  ltc_status_t       status;
  logic [SLOT_W-1:0] slot;
  logic [USED_W-1:0] used_slots;
  logic [CNT_W-1:0]  hits;
  logic [CNT_W-1:0]  misses;
  logic [CNT_W-1:0]  not_cached;

  modport source (output valid, status, slot, used_slots, hits, misses, not_cached,
                  input ready);
  modport sink   (input valid, status, slot, used_slots, hits, misses, not_cached,
                  output ready);
endinterface

### sv/ltc_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module ltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### sv/ltc_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the lru tag cache: dispatch, slot scan, decision, result
// depends on ltc_pkg

module ltc_ctrl import ltc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ltc_sts_t sts,
  output ltc_cmd_t cmd
);

  ltc_state_t        state_r, state_nxt;
  logic [USED_W-1:0] idx_r;
  logic              pend_r;
  logic [SLOT_W-1:0] cidx_r;
  logic              issue;

  // one slot read per cycle until every filled slot is out or a hit is seen
  assign issue = (state_r == S_SCAN) && (idx_r < sts.used_cnt) && !sts.found;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_nxt = sts.need_scan ? S_SCAN : S_RESULT;
      end
      S_SCAN: begin
        if (sts.found || (!issue && !pend_r)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // no beat is taken while reset is held
  always_comb begin
    in_ready     = (state_r == S_IDLE) && rst_n;
    cmd.load     = (state_r == S_IDLE) && rst_n && in_valid;
    cmd.classify = (state_r == S_DISPATCH);
    cmd.rd_en    = issue;
    cmd.rd_addr  = idx_r[SLOT_W-1:0];
    cmd.cmp_en   = (state_r == S_SCAN) && pend_r;
    cmd.cmp_idx  = cidx_r;
    cmd.decide   = (state_r == S_DECIDE);
    cmd.commit   = (state_r == S_RESULT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DISPATCH) begin
      idx_r <= '0;
    end else if (issue) begin
      idx_r <= idx_r + USED_W'(1);
    end
    if (issue) begin
      cidx_r <= idx_r[SLOT_W-1:0];
    end
  end

endmodule

### sv/ltc_dp.sv
`timescale 1ns / 1ps
// datapath of the lru tag cache: slot memories, compare, counters, result register
// depends on ltc_pkg and ltc_ram

module ltc_dp import ltc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ltc_cmd_t               cmd,
  output ltc_sts_t               sts,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  ltc_kind_t              in_kind,
  input  logic [KEY_BITS-1:0]    in_key,
  input  logic                   in_cacheable,
  input  logic [FRAME_BITS-1:0]  in_frame_now,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ltc_status_t            out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [USED_W-1:0]      out_used_slots,
  output logic [CNT_W-1:0]       out_hits,
  output logic [CNT_W-1:0]       out_misses,
  output logic [CNT_W-1:0]       out_not_cached
);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  logic [CAP_W-1:0]      capacity_r;
  logic [AGE_W-1:0]      age_thr_r;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic [CNT_W-1:0]      hits_r, hits_nxt;
  logic [CNT_W-1:0]      misses_r, misses_nxt;
  logic [CNT_W-1:0]      nc_r, nc_nxt;

  ltc_kind_t             kind_r;
  logic [KEY_BITS-1:0]   key_r;
  logic                  cach_r;
  logic [FRAME_BITS-1:0] now_r;

  logic                  found_r;
  logic [SLOT_W-1:0]     hit_idx_r;
  logic [FRAME_BITS-1:0] min_r;
  logic [SLOT_W-1:0]     old_idx_r;
  ltc_status_t           res_status_r;
  logic [SLOT_W-1:0]     res_slot_r;

  logic                  out_valid_r;
  ltc_status_t           out_status_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [USED_W-1:0]     out_used_r;
  logic [CNT_W-1:0]      out_hits_r, out_misses_r, out_nc_r;

  logic [CAPX_W-1:0]     cap_x;
  logic [USED_W-1:0]     cap_eff;
  logic                  cap_zero, full, is_look, is_ins;
  logic                  alloc, replace, hit_wr;
  logic [FRAME_BITS-1:0] age;
  logic [KEY_BITS-1:0]   key_rd;
  logic [FRAME_BITS-1:0] stamp_rd;
  logic                  key_we, stamp_we;
  logic [SLOT_W-1:0]     key_waddr, stamp_waddr;

  // usable slots: capacity limited to the table size
  always_comb begin
    cap_x   = CAPX_W'(capacity_r);
    cap_eff = (cap_x > CAPX_W'(SLOTS)) ? USED_W'(SLOTS) : USED_W'(cap_x);
  end

  assign cap_zero = (cap_eff == '0);
  assign full     = (used_r >= cap_eff);
  assign is_look  = (kind_r == KIND_LOOKUP) && cach_r;
  assign is_ins   = (kind_r == KIND_INSERT) && cach_r;

  assign sts.need_scan = (is_look && (used_r != '0)) || (is_ins && !cap_zero && full);
  assign sts.found     = found_r;
  assign sts.used_cnt  = used_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  // modular frame age of the least recently used slot
  assign age     = now_r - min_r;
  assign alloc   = cmd.classify && is_ins && !cap_zero && !full;
  assign replace = cmd.decide && (kind_r == KIND_INSERT) && (age > FRAME_BITS'(age_thr_r));
  assign hit_wr  = cmd.decide && (kind_r == KIND_LOOKUP) && found_r;

  assign key_we      = alloc || replace;
  assign key_waddr   = alloc ? used_r[SLOT_W-1:0] : old_idx_r;
  assign stamp_we    = alloc || replace || hit_wr;
  assign stamp_waddr = alloc ? used_r[SLOT_W-1:0] : (hit_wr ? hit_idx_r : old_idx_r);

  ltc_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_r),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (key_rd)
  );

  ltc_ram #(.WIDTH(FRAME_BITS), .DEPTH(SLOTS)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (now_r),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (stamp_rd)
  );

  // counter and fill updates at the end of a request
  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    nc_nxt     = nc_r;
    used_nxt   = used_r;
    case (res_status_r)
      ST_HIT:     hits_nxt   = sat_inc(hits_r);
      ST_MISS:    misses_nxt = sat_inc(misses_r);
      ST_NOCACHE: nc_nxt     = sat_inc(nc_r);
      ST_ALLOC:   used_nxt   = used_r + USED_W'(1);
      default:    ;
    endcase
    if (kind_r == KIND_CLEAR) begin
      hits_nxt   = '0;
      misses_nxt = '0;
      nc_nxt     = '0;
    end
    if (kind_r == KIND_FLUSH) begin
      used_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_W'(CAP_RESET);
      age_thr_r   <= AGE_W'(AGE_RESET);
      used_r      <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      nc_r        <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        used_r   <= used_nxt;
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
        nc_r     <= nc_nxt;
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_CAPACITY: begin
            capacity_r <= cfg_wdata[CAP_W-1:0];
            used_r     <= '0;
          end
          CFG_AGE_THRESHOLD: age_thr_r <= cfg_wdata[AGE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.classify) begin
        found_r <= 1'b0;
      end else if (cmd.cmp_en && is_look && !found_r && (key_rd == key_r)) begin
        found_r <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request payload, scan results and result beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      key_r  <= in_key;
      cach_r <= in_cacheable;
      now_r  <= in_frame_now;
    end
    if (cmd.cmp_en) begin
      if (kind_r == KIND_LOOKUP) begin
        if (!found_r && (key_rd == key_r)) hit_idx_r <= cmd.cmp_idx;
      end else if ((cmd.cmp_idx == '0) || (stamp_rd < min_r)) begin
        min_r     <= stamp_rd;
        old_idx_r <= cmd.cmp_idx;
      end
    end
    if (cmd.classify) begin
      res_slot_r <= alloc ? used_r[SLOT_W-1:0] : '0;
      if (!cach_r && ((kind_r == KIND_LOOKUP) || (kind_r == KIND_INSERT))) begin
        res_status_r <= ST_NOCACHE;
      end else if (kind_r == KIND_LOOKUP) begin
        res_status_r <= ST_MISS;
      end else if (kind_r == KIND_INSERT) begin
        res_status_r <= alloc ? ST_ALLOC : ST_REJECTED;
      end else begin
        res_status_r <= ST_DONE;
      end
    end
    if (hit_wr) begin
      res_status_r <= ST_HIT;
      res_slot_r   <= hit_idx_r;
    end else if (replace) begin
      res_status_r <= ST_REPLACED;
      res_slot_r   <= old_idx_r;
    end
    if (cmd.commit) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_used_r   <= used_nxt;
      out_hits_r   <= hits_nxt;
      out_misses_r <= misses_nxt;
      out_nc_r     <= nc_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_used_slots = out_used_r;
  assign out_hits       = out_hits_r;
  assign out_misses     = out_misses_r;
  assign out_not_cached = out_nc_r;

endmodule

### sv/lru_tag_cache_with_age_guard_top.sv
`timescale 1ns / 1ps
// top level of the lru tag cache with age-guarded replacement
// depends on ltc_pkg, ltc_in_if, ltc_out_if, ltc_ctrl, ltc_dp

// Fully associative tag cache of SLOTS entries (key plus last-used frame stamp,
// each in its own single-port-read ram) with lookup, insert, flush and
// clear-statistics requests; every request beat yields exactly one result beat
// carrying the status, the slot touched, the fill count and the three
// saturating counters. One request is worked on at a time. Flush, clear,
// uncacheable requests, lookups on an empty table and inserts into a free slot
// skip the scan and go from dispatch straight to the result; a lookup reads
// one slot per cycle from the key ram and stops at the first matching slot, or
// after every filled slot on a miss; an insert into a full table walks every
// stamp for the least recently used slot. The one read port of each slot ram
// sets that pace. A finished result sits in an output register, so a new
// request is taken while the previous beat still waits on out_if.ready. Slot
// contents are never cleared: the fill count bounds every read, so no clearing
// pass runs after reset. Configuration writes (capacity, age threshold) take
// effect at once and must land while the block is idle; writing capacity
// empties the table.

module lru_tag_cache_with_age_guard_top import ltc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ltc_in_if.sink                in_if,
  ltc_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ltc_cmd_t cmd;
  ltc_sts_t sts;

  // sequencer: dispatch, scan one slot per cycle, decide, hand off result
  ltc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot rams, compare and age check, counters, result register
  ltc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_if.kind),
    .in_key         (in_if.key),
    .in_cacheable   (in_if.cacheable),
    .in_frame_now   (in_if.frame_now),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_status     (out_if.status),
    .out_slot       (out_if.slot),
    .out_used_slots (out_if.used_slots),
    .out_hits       (out_if.hits),
    .out_misses     (out_if.misses),
    .out_not_cached (out_if.not_cached)
  );

  // a committed result shows up as a valid beat
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_if.valid)
    else $error("committed result not presented");

  // one request in flight: after an accepted beat the input closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second request taken while one is in flight");

  // scans never read past the filled slots
  a_scan_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (USED_W'(cmd.rd_addr) < sts.used_cnt))
    else $error("slot read beyond fill count");

  // fill count never exceeds the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.used_slots <= USED_W'(SLOTS)))
    else $error("fill count beyond table size");

endmodule
